// ===== rtl/core/ptc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the page translator with clock replacement
package ptc_pkg;

    localparam int ADDR_BITS     = 32;
    localparam int OFFSET_BITS   = 16;
    localparam int FRAME_BITS    = 7;
    localparam int FRAME_SLOTS   = 128;
    localparam int PHYS_BITS     = 23;
    localparam int CNT_BITS      = 32;
    localparam int FC_BITS       = 8;
    localparam int SHIFT_BITS    = 5;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAGE_SHIFT  = 1'd1;

    localparam logic [FC_BITS-1:0]    FRAME_COUNT_RST = 8'd8;
    localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_RST  = 5'd12;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MAX       = 5'd16;
    localparam logic [FC_BITS-1:0]    FC_MAX          = 8'd128;

    // configuration after clamping
    typedef struct packed {
        logic [FC_BITS-1:0]    frame_count;
        logic [SHIFT_BITS-1:0] page_shift;
    } t_cfg;

    typedef struct packed {
        logic                   page_hit;
        logic [ADDR_BITS-1:0]   page_index;
        logic [OFFSET_BITS-1:0] page_offset;
        logic [FRAME_BITS-1:0]  frame_used;
        logic [PHYS_BITS-1:0]   phys_addr;
        logic                   out_of_range;
        logic [CNT_BITS-1:0]    reference_total;
        logic [CNT_BITS-1:0]    fault_total;
    } t_result;

endpackage

// ===== rtl/core/ptc_in_if.sv =====
`timescale 1ns / 1ps
// address channel: one virtual address per transaction
interface ptc_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptc_pkg::ADDR_BITS-1:0]  virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink   (input valid, input virt_addr, output ready);
endinterface

// ===== rtl/core/ptc_out_if.sv =====
`timescale 1ns / 1ps
// translation result channel
interface ptc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             page_hit;
    logic [ptc_pkg::ADDR_BITS-1:0]    page_index;
    logic [ptc_pkg::OFFSET_BITS-1:0]  page_offset;
    logic [ptc_pkg::FRAME_BITS-1:0]   frame_used;
    logic [ptc_pkg::PHYS_BITS-1:0]    phys_addr;
    logic                             out_of_range;
    logic [ptc_pkg::CNT_BITS-1:0]     reference_total;
    logic [ptc_pkg::CNT_BITS-1:0]     fault_total;

    modport source (output valid, output page_hit, output page_index, output page_offset,
                    output frame_used, output phys_addr, output out_of_range,
                    output reference_total, output fault_total, input ready);
    modport sink   (input valid, input page_hit, input page_index, input page_offset,
                    input frame_used, input phys_addr, input out_of_range,
                    input reference_total, input fault_total, output ready);
endinterface

// ===== rtl/core/ptc_ram.sv =====
`timescale 1ns / 1ps
// simple dual-port ram, one write and one registered read, write-first on collision
module ptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= (i_we && (i_waddr == i_raddr)) ? i_wdata : r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ptc_ctrl.sv =====
`timescale 1ns / 1ps
// translation sequencer: page table lookup, frame allocation and clock sweep
module ptc_ctrl #(
    parameter int VIRTUAL_PAGES = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptc_pkg::t_cfg                        i_cfg,
    input  logic                                 i_in_valid,
    input  logic [ptc_pkg::ADDR_BITS-1:0]        i_in_addr,
    output logic                                 o_in_ready,
    output logic                                 o_pm_we,
    output logic [$clog2(VIRTUAL_PAGES)-1:0]     o_pm_waddr,
    output logic [ptc_pkg::FRAME_BITS:0]         o_pm_wdata,
    output logic                                 o_pm_re,
    output logic [$clog2(VIRTUAL_PAGES)-1:0]     o_pm_raddr,
    input  logic [ptc_pkg::FRAME_BITS:0]         i_pm_rdata,
    output logic                                 o_fm_we,
    output logic [ptc_pkg::FRAME_BITS-1:0]       o_fm_waddr,
    output logic [$clog2(VIRTUAL_PAGES):0]       o_fm_wdata,
    output logic                                 o_fm_re,
    output logic [ptc_pkg::FRAME_BITS-1:0]       o_fm_raddr,
    input  logic [$clog2(VIRTUAL_PAGES):0]       i_fm_rdata,
    input  logic                                 i_out_free,
    output logic                                 o_res_valid,
    output ptc_pkg::t_result                     o_res
);

    localparam int PAGE_BITS = $clog2(VIRTUAL_PAGES);
    localparam int AB = ptc_pkg::ADDR_BITS;
    localparam int FB = ptc_pkg::FRAME_BITS;
    localparam logic [AB:0] PAGE_LIMIT = (AB + 1)'(VIRTUAL_PAGES);
    localparam logic [PAGE_BITS-1:0] CLR_LAST = PAGE_BITS'(VIRTUAL_PAGES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_HIT   = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                        r_state, n_state;
    logic [PAGE_BITS-1:0]              r_clr_addr, n_clr_addr;
    logic [AB-1:0]                     r_page, n_page;
    logic [ptc_pkg::OFFSET_BITS-1:0]   r_offset, n_offset;
    logic [ptc_pkg::SHIFT_BITS-1:0]    r_shift, n_shift;
    logic                              r_oor, n_oor;
    logic                              r_hit, n_hit;
    logic [FB-1:0]                     r_frame, n_frame;
    logic [FB-1:0]                     r_hand, n_hand;
    logic [ptc_pkg::FC_BITS-1:0]       r_alloc, n_alloc;
    logic [ptc_pkg::CNT_BITS-1:0]      r_ref_cnt, n_ref_cnt;
    logic [ptc_pkg::CNT_BITS-1:0]      r_fault_cnt, n_fault_cnt;

    logic [AB-1:0]                     w_page;
    logic [ptc_pkg::OFFSET_BITS-1:0]   w_offset;
    logic                              w_oor;
    logic                              w_pm_valid;
    logic [FB-1:0]                     w_pm_frame;
    logic                              w_fm_ref;
    logic [PAGE_BITS-1:0]              w_fm_owner;
    logic [FB-1:0]                     w_hand_start;
    logic [FB-1:0]                     w_hand_next;

    // split of the incoming address
    assign w_page   = i_in_addr >> i_cfg.page_shift;
    assign w_offset = ptc_pkg::OFFSET_BITS'(i_in_addr &
                      ((AB'(1) << i_cfg.page_shift) - AB'(1)));
    assign w_oor    = {1'b0, w_page} >= PAGE_LIMIT;

    assign w_pm_valid = i_pm_rdata[FB];
    assign w_pm_frame = i_pm_rdata[FB-1:0];
    assign w_fm_ref   = i_fm_rdata[PAGE_BITS];
    assign w_fm_owner = i_fm_rdata[PAGE_BITS-1:0];

    // hand restarts at zero if the frame count shrank below it
    assign w_hand_start = ({1'b0, r_hand} >= i_cfg.frame_count) ? '0 : r_hand;
    assign w_hand_next  = (({1'b0, r_hand} + ptc_pkg::FC_BITS'(1)) == i_cfg.frame_count)
                          ? '0 : r_hand + FB'(1);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_page      = r_page;
        n_offset    = r_offset;
        n_shift     = r_shift;
        n_oor       = r_oor;
        n_hit       = r_hit;
        n_frame     = r_frame;
        n_hand      = r_hand;
        n_alloc     = r_alloc;
        n_ref_cnt   = r_ref_cnt;
        n_fault_cnt = r_fault_cnt;
        o_in_ready  = 1'b0;
        o_pm_we     = 1'b0;
        o_pm_waddr  = r_page[PAGE_BITS-1:0];
        o_pm_wdata  = '0;
        o_pm_re     = 1'b0;
        o_pm_raddr  = w_page[PAGE_BITS-1:0];
        o_fm_we     = 1'b0;
        o_fm_waddr  = r_frame;
        o_fm_wdata  = '0;
        o_fm_re     = 1'b0;
        o_fm_raddr  = r_hand;
        o_res_valid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_pm_we    = 1'b1;
                o_pm_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + PAGE_BITS'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_pm_re  = 1'b1;
                    n_page   = w_page;
                    n_offset = w_offset;
                    n_shift  = i_cfg.page_shift;
                    n_oor    = w_oor;
                    n_hit    = 1'b0;
                    n_frame  = '0;
                    n_state  = w_oor ? S_DONE : S_LOOK;
                end
            end
            S_LOOK: begin
                n_ref_cnt = (&r_ref_cnt) ? r_ref_cnt : r_ref_cnt + ptc_pkg::CNT_BITS'(1);
                if (w_pm_valid) begin
                    n_hit      = 1'b1;
                    n_frame    = w_pm_frame;
                    o_fm_re    = 1'b1;
                    o_fm_raddr = w_pm_frame;
                    n_state    = S_HIT;
                end else begin
                    n_fault_cnt = (&r_fault_cnt) ? r_fault_cnt
                                                 : r_fault_cnt + ptc_pkg::CNT_BITS'(1);
                    if (r_alloc < i_cfg.frame_count) begin
                        // a never-used frame is still free
                        n_frame    = r_alloc[FB-1:0];
                        n_alloc    = r_alloc + ptc_pkg::FC_BITS'(1);
                        o_pm_we    = 1'b1;
                        o_pm_wdata = {1'b1, r_alloc[FB-1:0]};
                        o_fm_we    = 1'b1;
                        o_fm_waddr = r_alloc[FB-1:0];
                        o_fm_wdata = {1'b1, r_page[PAGE_BITS-1:0]};
                        n_state    = S_DONE;
                    end else begin
                        n_hand     = w_hand_start;
                        o_fm_re    = 1'b1;
                        o_fm_raddr = w_hand_start;
                        n_state    = S_SWEEP;
                    end
                end
            end
            S_HIT: begin
                o_fm_we    = 1'b1;
                o_fm_wdata = {1'b1, w_fm_owner};
                n_state    = S_DONE;
            end
            S_SWEEP: begin
                n_hand = w_hand_next;
                if (w_fm_ref) begin
                    // second chance: clear and move on
                    o_fm_we    = 1'b1;
                    o_fm_waddr = r_hand;
                    o_fm_wdata = {1'b0, w_fm_owner};
                    o_fm_re    = 1'b1;
                    o_fm_raddr = w_hand_next;
                end else begin
                    // victim found, unmap its old page
                    n_frame    = r_hand;
                    o_pm_we    = 1'b1;
                    o_pm_waddr = w_fm_owner;
                    o_pm_wdata = '0;
                    n_state    = S_FILL;
                end
            end
            S_FILL: begin
                o_pm_we    = 1'b1;
                o_pm_wdata = {1'b1, r_frame};
                o_fm_we    = 1'b1;
                o_fm_wdata = {1'b1, r_page[PAGE_BITS-1:0]};
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hand      <= '0;
            r_alloc     <= '0;
            r_ref_cnt   <= '0;
            r_fault_cnt <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_hand      <= n_hand;
            r_alloc     <= n_alloc;
            r_ref_cnt   <= n_ref_cnt;
            r_fault_cnt <= n_fault_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page   <= n_page;
        r_offset <= n_offset;
        r_shift  <= n_shift;
        r_oor    <= n_oor;
        r_hit    <= n_hit;
        r_frame  <= n_frame;
    end

    always_comb begin
        o_res.page_hit         = r_hit;
        o_res.page_index       = r_page;
        o_res.page_offset      = r_offset;
        o_res.frame_used       = r_oor ? '0 : r_frame;
        o_res.phys_addr        = r_oor ? '0
            : ((ptc_pkg::PHYS_BITS'(r_frame) << r_shift) | ptc_pkg::PHYS_BITS'(r_offset));
        o_res.out_of_range     = r_oor;
        o_res.reference_total  = r_ref_cnt;
        o_res.fault_total      = r_fault_cnt;
    end

endmodule

// ===== rtl/core/page_translate_clock_replace.sv =====
`timescale 1ns / 1ps
// top level: page translation with single-hand clock replacement
//
//  channel   dir  handshake        transaction carries
//  i_in      in   valid / ready    virt_addr
//  o_out     out  valid / ready    hit, page, offset, frame, physical address, flags, totals
//  i_cfg_*   in   write enable     register index and data, no back-pressure
//
//  a hit runs S_IDLE, S_LOOK, S_HIT, S_DONE; a fault on a free frame S_IDLE, S_LOOK, S_DONE;
//  a fault with all frames in use S_IDLE, S_LOOK, S_SWEEP (the hand passes each referenced
//  frame, at most frame_count, up to the victim), S_FILL, S_DONE; the result register is
//  loaded as S_DONE returns to S_IDLE; the pace is set by the read-modify-write through the
//  registered-read page and frame tables; after reset the page table is swept clear, one
//  entry per cycle, with i_in.ready low; configuration writes are taken meanwhile; the
//  result register lets the next address be accepted while o_out is stalled
module page_translate_clock_replace #(
    parameter int VIRTUAL_PAGES = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    ptc_in_if.sink                                i_in,
    ptc_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [ptc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int PAGE_BITS = $clog2(VIRTUAL_PAGES);
    localparam int FB = ptc_pkg::FRAME_BITS;

    // configuration registers
    logic [ptc_pkg::FC_BITS-1:0]    r_frame_count;
    logic [ptc_pkg::SHIFT_BITS-1:0] r_page_shift;
    ptc_pkg::t_cfg                  w_cfg;

    // page table port
    logic                 w_pm_we;
    logic [PAGE_BITS-1:0] w_pm_waddr;
    logic [FB:0]          w_pm_wdata;
    logic                 w_pm_re;
    logic [PAGE_BITS-1:0] w_pm_raddr;
    logic [FB:0]          w_pm_rdata;

    // frame table port: reference bit over owner page
    logic                 w_fm_we;
    logic [FB-1:0]        w_fm_waddr;
    logic [PAGE_BITS:0]   w_fm_wdata;
    logic                 w_fm_re;
    logic [FB-1:0]        w_fm_raddr;
    logic [PAGE_BITS:0]   w_fm_rdata;

    // result register
    logic                 r_out_valid;
    ptc_pkg::t_result     r_out;
    ptc_pkg::t_result     w_res;
    logic                 w_res_valid;
    logic                 w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= ptc_pkg::FRAME_COUNT_RST;
            r_page_shift  <= ptc_pkg::PAGE_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ptc_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                ptc_pkg::CFG_PAGE_SHIFT:  r_page_shift  <= i_cfg_data[ptc_pkg::SHIFT_BITS-1:0];
                default: begin
                    r_frame_count <= r_frame_count;
                end
            endcase
        end
    end

    // zero frames acts as one, oversize counts and shifts clamp
    always_comb begin
        w_cfg.frame_count = r_frame_count;
        if (r_frame_count == '0) begin
            w_cfg.frame_count = ptc_pkg::FC_BITS'(1);
        end else if (r_frame_count > ptc_pkg::FC_MAX) begin
            w_cfg.frame_count = ptc_pkg::FC_MAX;
        end
        w_cfg.page_shift = (r_page_shift > ptc_pkg::SHIFT_MAX) ? ptc_pkg::SHIFT_MAX
                                                               : r_page_shift;
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    ptc_ctrl #(
        .VIRTUAL_PAGES (VIRTUAL_PAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in.valid),
        .i_in_addr   (i_in.virt_addr),
        .o_in_ready  (i_in.ready),
        .o_pm_we     (w_pm_we),
        .o_pm_waddr  (w_pm_waddr),
        .o_pm_wdata  (w_pm_wdata),
        .o_pm_re     (w_pm_re),
        .o_pm_raddr  (w_pm_raddr),
        .i_pm_rdata  (w_pm_rdata),
        .o_fm_we     (w_fm_we),
        .o_fm_waddr  (w_fm_waddr),
        .o_fm_wdata  (w_fm_wdata),
        .o_fm_re     (w_fm_re),
        .o_fm_raddr  (w_fm_raddr),
        .i_fm_rdata  (w_fm_rdata),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // page table: valid bit over frame number
    ptc_ram #(
        .WIDTH (FB + 1),
        .DEPTH (VIRTUAL_PAGES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_pm_we),
        .i_waddr (w_pm_waddr),
        .i_wdata (w_pm_wdata),
        .i_re    (w_pm_re),
        .i_raddr (w_pm_raddr),
        .o_rdata (w_pm_rdata)
    );

    // frame table, write-first so the sweep sees its own clear when the hand stays put
    ptc_ram #(
        .WIDTH (PAGE_BITS + 1),
        .DEPTH (ptc_pkg::FRAME_SLOTS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_fm_we),
        .i_waddr (w_fm_waddr),
        .i_wdata (w_fm_wdata),
        .i_re    (w_fm_re),
        .i_raddr (w_fm_raddr),
        .o_rdata (w_fm_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.page_hit         = r_out.page_hit;
    assign o_out.page_index       = r_out.page_index;
    assign o_out.page_offset      = r_out.page_offset;
    assign o_out.frame_used       = r_out.frame_used;
    assign o_out.phys_addr        = r_out.phys_addr;
    assign o_out.out_of_range     = r_out.out_of_range;
    assign o_out.reference_total  = r_out.reference_total;
    assign o_out.fault_total      = r_out.fault_total;

`ifndef SYNTHESIS
    // a finished translation is only handed over when the result register can take it
    a_res_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_out_free)
        else $error("result produced while output register is occupied");

    // an out-of-range page is never a hit and maps to nothing
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_range) |->
        (!o_out.page_hit && (o_out.frame_used == '0) && (o_out.phys_addr == '0)))
        else $error("out-of-range result carries a mapping");

    // faults are a subset of references
    a_fault_le_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.fault_total <= o_out.reference_total))
        else $error("fault total exceeds reference total");
`endif

endmodule
